/* rtl/core/pmp_rdc_pkg.sv */
package pmp_rdc_pkg;

  // table size and field widths
  localparam int NUM_ENTRIES = 16;
  localparam int ENTRY_W     = 4;
  localparam int ADDR_W      = 64;
  localparam int WORD_W      = 54;
  localparam int LIMIT_W     = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // request codes (s_axis_tuser)
  localparam logic [1:0] REQ_WR_ADDR = 2'd0;
  localparam logic [1:0] REQ_WR_CFG  = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  // access kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  // address-matching mode, bits 4:3 of a config byte
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  typedef struct packed {
    logic              load;  // latch a new request
    logic              exec;  // update tables / run comparator bank
    logic              pick;  // priority pick into the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ENTRY_W-1:0] entry_index;
    logic              cfg_group;
    logic [63:0]       word_value;
    logic [ADDR_W-1:0] access_address;
    logic [1:0]        access_kind;
  } req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] hit_entry;
    logic              hit;
    logic              allow;
  } res_t;

endpackage

/* rtl/core/pmp_rdc_ctrl.sv */
module pmp_rdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pmp_rdc_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;
  logic       in_acc;
  logic       pick_fire;

  assign out_free  = !out_valid || out_ready;
  assign pick_fire = (state == ST_PICK) && out_free;
  assign in_ready  = (state == ST_IDLE) || pick_fire;
  assign in_acc    = in_valid && in_ready;

  assign cmd.load = in_acc;
  assign cmd.exec = (state == ST_EXEC);
  assign cmd.pick = pick_fire;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (pick_fire) state_next = in_acc ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (pick_fire) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/core/pmp_rdc_dpath.sv */
module pmp_rdc_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pmp_rdc_pkg::cmd_t                      cmd,
  input  pmp_rdc_pkg::req_t                      req_in,
  input  logic                                   cfg_we,
  input  logic [pmp_rdc_pkg::LIMIT_W-1:0]        cfg_data,
  output pmp_rdc_pkg::res_t                      res
);

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } bounds_t;

  // inclusive [lo, hi] for one entry; lo > hi means empty
  function automatic bounds_t decode_bounds(
    input logic [pmp_rdc_pkg::WORD_W-1:0] word,
    input logic [pmp_rdc_pkg::WORD_W-1:0] prev,
    input logic [1:0]                     mode,
    input logic                           first
  );
    bounds_t                          b;
    logic [pmp_rdc_pkg::WORD_W-1:0]   cleared;
    logic [pmp_rdc_pkg::WORD_W-1:0]   ones_mask;
    b.lo      = '0;
    b.hi      = '0;
    // clear trailing ones; mask covers them plus the first zero
    cleared   = word & (word + 54'd1);
    ones_mask = word ^ (word + 54'd1);
    case (mode)
      pmp_rdc_pkg::MODE_TOR: begin
        if (!first) b.lo = {8'd0, prev, 2'b00};
        if (word == '0) begin
          b.lo = 64'd1;
          b.hi = '0;
        end else begin
          b.hi = {8'd0, word, 2'b00} - 64'd1;
        end
      end
      pmp_rdc_pkg::MODE_NA4: begin
        b.lo = {8'd0, word, 2'b00};
        b.hi = {8'd0, word, 2'b11};
      end
      pmp_rdc_pkg::MODE_NAPOT: begin
        if (&word) begin
          b.lo = '0;
          b.hi = '1;
        end else begin
          b.lo = {8'd0, cleared, 2'b00};
          b.hi = {8'd0, cleared, 2'b00} | {8'd0, ones_mask, 2'b11};
        end
      end
      default: begin
      end
    endcase
    return b;
  endfunction

  pmp_rdc_pkg::req_t                      req_q;
  logic [pmp_rdc_pkg::LIMIT_W-1:0]        entries_in_use;
  logic [pmp_rdc_pkg::LIMIT_W-1:0]        limit;

  logic [pmp_rdc_pkg::WORD_W-1:0]  addr_words   [pmp_rdc_pkg::NUM_ENTRIES];
  logic [pmp_rdc_pkg::WORD_W-1:0]  prev_words   [pmp_rdc_pkg::NUM_ENTRIES];
  logic [63:0]                     region_start [pmp_rdc_pkg::NUM_ENTRIES];
  logic [63:0]                     region_end   [pmp_rdc_pkg::NUM_ENTRIES];
  logic [3:0]                      region_perms [pmp_rdc_pkg::NUM_ENTRIES];
  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] region_enable;

  logic [7:0]                      cfg_byte     [pmp_rdc_pkg::NUM_ENTRIES];
  bounds_t                         bnd          [pmp_rdc_pkg::NUM_ENTRIES];
  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] grp_hit;
  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] match;
  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] perm_bit;

  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] match_vec;
  logic [pmp_rdc_pkg::NUM_ENTRIES-1:0] perm_vec;
  pmp_rdc_pkg::res_t               pick_res;

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= pmp_rdc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      entries_in_use <= cfg_data;
    end
  end

  assign limit = (entries_in_use > pmp_rdc_pkg::LIMIT_W'(pmp_rdc_pkg::NUM_ENTRIES)) ?
                 pmp_rdc_pkg::LIMIT_W'(pmp_rdc_pkg::NUM_ENTRIES) : entries_in_use;

  // TOR lower bound comes from the neighbor below
  always_comb begin
    prev_words[0] = '0;
    for (int j = 1; j < pmp_rdc_pkg::NUM_ENTRIES; j++) begin
      prev_words[j] = addr_words[j-1];
    end
  end

  // per-entry decoders and comparator bank
  always_comb begin
    for (int j = 0; j < pmp_rdc_pkg::NUM_ENTRIES; j++) begin
      cfg_byte[j] = req_q.word_value[8*(j%8) +: 8];
      bnd[j]      = decode_bounds(addr_words[j], prev_words[j], cfg_byte[j][4:3], 1'(j == 0));
      grp_hit[j]  = (req_q.cfg_group == 1'(j / 8));
      match[j]    = region_enable[j]
                    && (pmp_rdc_pkg::LIMIT_W'(j) < limit)
                    && (req_q.access_address >= region_start[j])
                    && (req_q.access_address <= region_end[j]);
      case (req_q.access_kind)
        pmp_rdc_pkg::KIND_READ:  perm_bit[j] = region_perms[j][0];
        pmp_rdc_pkg::KIND_WRITE: perm_bit[j] = region_perms[j][1];
        pmp_rdc_pkg::KIND_EXEC:  perm_bit[j] = region_perms[j][2];
        default:                 perm_bit[j] = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < pmp_rdc_pkg::NUM_ENTRIES; j++) begin
        addr_words[j] <= '0;
      end
      region_enable <= '0;
    end else if (cmd.exec) begin
      for (int j = 0; j < pmp_rdc_pkg::NUM_ENTRIES; j++) begin
        if ((req_q.req_type == pmp_rdc_pkg::REQ_WR_ADDR)
            && (req_q.entry_index == pmp_rdc_pkg::ENTRY_W'(j))) begin
          addr_words[j] <= req_q.word_value[pmp_rdc_pkg::WORD_W-1:0];
        end
        if ((req_q.req_type == pmp_rdc_pkg::REQ_WR_CFG) && grp_hit[j]) begin
          if (cfg_byte[j][4:3] == pmp_rdc_pkg::MODE_OFF) begin
            region_enable[j] <= 1'b0;
          end else begin
            region_enable[j] <= 1'b1;
            region_start[j]  <= bnd[j].lo;
            region_end[j]    <= bnd[j].hi;
            region_perms[j]  <= {cfg_byte[j][7], cfg_byte[j][2:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      match_vec <= (req_q.req_type == pmp_rdc_pkg::REQ_CHECK) ? match : '0;
      perm_vec  <= perm_bit;
    end
  end

  // lowest matching entry wins
  always_comb begin
    pick_res = '0;
    for (int j = pmp_rdc_pkg::NUM_ENTRIES - 1; j >= 0; j--) begin
      if (match_vec[j]) begin
        pick_res.hit       = 1'b1;
        pick_res.hit_entry = pmp_rdc_pkg::ENTRY_W'(j);
        pick_res.allow     = perm_vec[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) res <= pick_res;
  end

endmodule

/* rtl/core/pmp_region_decode_and_check.sv */
// Physical memory protection: region table plus access checker.
//
// Input stream (s_axis_*): one request per transaction. tuser carries the
// request type: address word write, config word write, or access check.
// Output stream (m_axis_*): exactly one result per request. Writes and the
// unused request code return all zeros; a check returns allow, hit and the
// index of the lowest enabled region containing the address.
// Config channel (cfg_*): sets how many entries a check searches; always
// ready. The user must see that it is written only while no request is in
// flight; the block does not enforce this.
//
// Pipeline: the request register feeds the 16-way comparator bank (table
// update), whose registered match vector feeds the priority pick into the
// output register. A new request is taken as the previous one leaves the
// pick stage, but never while one is in the exec stage.
// Reset (rst, sync): clears all address words and region enables; the
// search length returns to 16. A stalled output holds its result; one more
// request is taken meanwhile and waits at the pick stage until it drains.
module pmp_region_decode_and_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [3:0] entry_index, [4] cfg_group, [68:5] word_value,
  // [132:69] access_address, [134:133] access_kind, [135] zero
  input  logic [135:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [0] allow, [1] hit, [5:2] hit_entry, [7:6] zero
  output logic [7:0]    m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [4:0]    cfg_data
);

  pmp_rdc_pkg::cmd_t cmd;
  pmp_rdc_pkg::req_t req_in;
  pmp_rdc_pkg::res_t res;

  assign req_in.req_type       = s_axis_tuser;
  assign req_in.entry_index    = s_axis_tdata[3:0];
  assign req_in.cfg_group      = s_axis_tdata[4];
  assign req_in.word_value     = s_axis_tdata[68:5];
  assign req_in.access_address = s_axis_tdata[132:69];
  assign req_in.access_kind    = s_axis_tdata[134:133];

  // register write is a single flop update; never back-pressured
  assign cfg_ready = 1'b1;

  pmp_rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  pmp_rdc_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_in   (req_in),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

/* rtl/core/pmp_rdc_checker.sv */
module pmp_rdc_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [7:0]    m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // a miss never grants and reports entry 0
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0] && (m_axis_tdata[5:2] == 4'd0))
    else $error("miss with allow or nonzero entry");

  // one request in the exec stage at a time
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // when an accepted request reaches the pick stage, the result is loaded if the output is free
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready ##2 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after request");

endmodule

bind pmp_region_decode_and_check pmp_rdc_checker u_pmp_rdc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import pmp_rdc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] REQ_NONE  = 2'd3;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] PERM_R   = 3'b001;
  localparam logic [2:0] PERM_W   = 3'b010;
  localparam logic [2:0] PERM_X   = 3'b100;
  localparam logic [2:0] PERM_RWX = 3'b111;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [135:0]  s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [7:0]    m_axis_tdata;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [4:0]    cfg_data = '0;

  pmp_region_decode_and_check dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow of the region table, kept in step with accepted requests
  // ---------------------------------------------------------------
  logic [WORD_W-1:0]      addr_word [NUM_ENTRIES];
  logic [ADDR_W-1:0]      rgn_lo    [NUM_ENTRIES];
  logic [ADDR_W-1:0]      rgn_hi    [NUM_ENTRIES];
  logic [3:0]             rgn_perm  [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] rgn_on;
  logic [LIMIT_W-1:0]     search_len;

  res_t pending_results[$];
  res_t oldest_result;

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      addr_word[i] = '0;
      rgn_lo[i] = '0;
      rgn_hi[i] = '0;
      rgn_perm[i] = '0;
    end
    rgn_on = '0;
    search_len = LIMIT_RESET;
  end

  // Decode one config byte into entry bounds at the time of the write
  task automatic decode_region(input int idx, input logic [7:0] cfg);
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    int ones;
    word = addr_word[idx];
    lo = '0;
    hi = '1;
    if (cfg[4:3] == MODE_OFF) begin
      // bounds and perms stay as they were
      rgn_on[idx] = 1'b0;
      return;
    end
    if (cfg[4:3] == MODE_TOR) begin
      if (idx > 0)
        lo = {8'd0, addr_word[idx-1], 2'b00};
      if (word == '0) begin
        lo = 64'd1;
        hi = 64'd0;
      end else begin
        hi = {8'd0, word, 2'b00} - 64'd1;
      end
    end else if (cfg[4:3] == MODE_NA4) begin
      lo = {8'd0, word, 2'b00};
      hi = lo + 64'd3;
    end else if (word != '1) begin
      ones = 0;
      while (ones < WORD_W && word[ones])
        ones++;
      lo = ({10'd0, word} & ~((64'd1 << ones) - 64'd1)) << 2;
      hi = lo + (64'd1 << (ones + 3)) - 64'd1;
    end
    rgn_on[idx] = 1'b1;
    rgn_lo[idx] = lo;
    rgn_hi[idx] = hi;
    rgn_perm[idx] = {cfg[7], cfg[2:0]};
  endtask

  // Apply one accepted request to the shadow table and queue its result
  task automatic predict_request(input req_t r);
    res_t res;
    int span;
    bit found;
    res = '0;
    found = 1'b0;
    span = (search_len > NUM_ENTRIES) ? NUM_ENTRIES : search_len;
    case (r.req_type)
      REQ_WR_ADDR: addr_word[r.entry_index] = r.word_value[WORD_W-1:0];
      REQ_WR_CFG: begin
        for (int i = 0; i < 8; i++)
          decode_region(r.cfg_group * 8 + i, r.word_value[8*i +: 8]);
      end
      REQ_CHECK: begin
        for (int i = 0; i < span; i++) begin
          if (!found && rgn_on[i] && r.access_address >= rgn_lo[i]
              && r.access_address <= rgn_hi[i]) begin
            found = 1'b1;
            res.hit = 1'b1;
            res.hit_entry = ENTRY_W'(i);
            res.allow = (r.access_kind == KIND_NONE) ? 1'b0 : rgn_perm[i][r.access_kind];
          end
        end
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] cfg_entry(input logic [2:0] perm, input logic [1:0] mode,
                                           input logic lock);
    return {lock, 2'b00, mode, perm};
  endfunction

  function automatic req_t make_req(input logic [1:0] kind_of_req, input logic [3:0] idx,
                                    input logic grp, input logic [63:0] val,
                                    input logic [63:0] addr, input logic [1:0] kind);
    req_t r;
    r.req_type = kind_of_req;
    r.entry_index = idx;
    r.cfg_group = grp;
    r.word_value = val;
    r.access_address = addr;
    r.access_kind = kind;
    return r;
  endfunction

  // Address words shaped for NAPOT sizing, plus small, raw and all-ones values
  function automatic logic [63:0] region_word_sample();
    logic [63:0] w;
    int k;
    w = rand64();
    case ($urandom_range(3))
      0: w = 64'($urandom_range(4096));
      1, 2: begin
        k = $urandom_range(WORD_W - 1);
        w = w | ((64'd1 << k) - 64'd1);
        w[k] = 1'b0;
      end
      default: ;
    endcase
    if ($urandom_range(19) == 0)
      w = '1;
    return w;
  endfunction

  // Addresses at, inside and just outside a region's bounds, or random
  function automatic logic [63:0] address_near_region();
    int i;
    logic [63:0] span;
    i = $urandom_range(NUM_ENTRIES - 1);
    span = rgn_hi[i] - rgn_lo[i];
    case ($urandom_range(5))
      0: return rgn_lo[i];
      1: return rgn_hi[i];
      2: return rgn_lo[i] - 64'd1;
      3: return rgn_hi[i] + 64'd1;
      4: begin
        if (rgn_hi[i] < rgn_lo[i] || span == '1)
          return rand64();
        return rgn_lo[i] + rand64() % (span + 64'd1);
      end
      default: return rand64();
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    r = make_req(REQ_NONE, 4'($urandom_range(15)), 1'($urandom_range(1)), rand64(),
                 rand64(), 2'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 18) begin
      r.req_type = REQ_WR_ADDR;
      r.word_value = region_word_sample();
    end else if (pick < 28) begin
      r.req_type = REQ_WR_CFG;
    end else if (pick < 95) begin
      r.req_type = REQ_CHECK;
      r.access_address = address_near_region();
    end
    return r;
  endfunction

  // One input transaction; starts and ends at a falling edge
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
    s_axis_tuser = r.req_type;
    s_axis_tdata = {1'b0, r.access_kind, r.access_address, r.word_value,
                    r.cfg_group, r.entry_index};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(r);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0)
      @(negedge clk);
  endtask

  // Search length write, only with nothing in flight
  task automatic write_search_len(input logic [LIMIT_W-1:0] len);
    wait_drained();
    cfg_data = len;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    search_len = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when requested
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every output transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata[0] !== oldest_result.allow) begin
          $error("allow: expected %0d, got %0d", oldest_result.allow, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[1] !== oldest_result.hit) begin
          $error("hit: expected %0d, got %0d", oldest_result.hit, m_axis_tdata[1]);
          errors++;
        end
        if (m_axis_tdata[5:2] !== oldest_result.hit_entry) begin
          $error("hit_entry: expected %0d, got %0d", oldest_result.hit_entry,
                 m_axis_tdata[5:2]);
          errors++;
        end
        if (m_axis_tdata[7:6] !== 2'b00) begin
          $error("pad: expected 0, got %0d", m_axis_tdata[7:6]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pmp_region_decode_and_check verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // Region modes, bounds edges, write results, unused codes
  task automatic test_directed_cases();
    logic [63:0] cfg_word;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(make_req(REQ_CHECK, 0, 0, '0, '0, KIND_READ));   // table empty: miss
    send_request(make_req(REQ_NONE, 4'hF, 1, '1, '1, KIND_NONE));
    // upper bits of the word are dropped
    send_request(make_req(REQ_WR_ADDR, 0, 1, 64'hFFC0_0000_0000_0100, '1, KIND_NONE));
    send_request(make_req(REQ_WR_ADDR, 1, 0, 64'h200, '0, KIND_READ));
    send_request(make_req(REQ_WR_ADDR, 2, 0, 64'h1003, '0, KIND_READ));
    send_request(make_req(REQ_WR_ADDR, 3, 0, 64'h0, '0, KIND_READ)); // TOR with zero top
    send_request(make_req(REQ_WR_ADDR, 4, 0, '1, '0, KIND_READ));    // NAPOT all ones
    send_request(make_req(REQ_WR_ADDR, 5, 0, 64'h3FF, '0, KIND_READ));
    cfg_word = {16'd0,
                cfg_entry(PERM_RWX, MODE_OFF, 1'b0),
                cfg_entry(PERM_R, MODE_NAPOT, 1'b0),
                cfg_entry(PERM_RWX, MODE_TOR, 1'b0),
                cfg_entry(PERM_RWX, MODE_NAPOT, 1'b1),
                cfg_entry(PERM_X, MODE_NA4, 1'b0),
                cfg_entry(PERM_R | PERM_W, MODE_TOR, 1'b0)};
    send_request(make_req(REQ_WR_CFG, 0, 0, cfg_word, '1, KIND_EXEC));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h0, KIND_READ));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h3FF, KIND_EXEC));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h400, KIND_WRITE));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h803, KIND_EXEC));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h4010, KIND_NONE)); // hit, still denied
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h401F, KIND_WRITE));
    send_request(make_req(REQ_CHECK, 4'hF, 1, '1, '1, KIND_READ));
    // group 1 all ones: NAPOT on zero words, locked RWX
    send_request(make_req(REQ_WR_CFG, 0, 1, '1, '0, KIND_READ));
    send_request(make_req(REQ_WR_ADDR, 15, 0, 64'h2A_AAAA_AAAA_AAAA, '0, KIND_READ));
    send_request(make_req(REQ_WR_CFG, 0, 0, '0, '0, KIND_READ));     // group 0 all off
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h5, KIND_READ));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h8, KIND_READ));
    // last entry as TOR, bottom taken from entry 14
    send_request(make_req(REQ_WR_CFG, 0, 1, {cfg_entry(PERM_W, MODE_TOR, 1'b0), 56'd0},
                          '0, KIND_READ));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'h1000, KIND_WRITE));
    send_request(make_req(REQ_CHECK, 0, 0, '0, 64'hAAAA_AAAA_AAAA_AAA7, KIND_WRITE));
  endtask

  // Checks under search lengths from 0 to 31, saturation included
  task automatic test_search_length();
    logic [LIMIT_W-1:0] lens [8] = '{5'd0, 5'd1, 5'd5, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31};
    send_idle_pct = 6;
    recv_stall_pct = 6;
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_request(make_req(REQ_WR_ADDR, ENTRY_W'(i), 0, region_word_sample(), rand64(),
                            KIND_READ));
    send_request(make_req(REQ_WR_CFG, 0, 0, rand64(), rand64(), KIND_READ));
    send_request(make_req(REQ_WR_CFG, 0, 1, rand64(), rand64(), KIND_READ));
    foreach (lens[n]) begin
      write_search_len(lens[n]);
      repeat (8)
        send_request(make_req(REQ_CHECK, 4'($urandom_range(15)), 1'($urandom_range(1)),
                              rand64(), address_near_region(), 2'($urandom_range(3))));
    end
  endtask

  // Output held off long enough for the pipeline to fill and stall input
  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_search_len(LIMIT_RESET);
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    repeat (40)
      send_request(random_request());
  endtask

  task automatic test_random_traffic();
    int idle_send [4] = '{0, 63, 0, 6};
    int idle_recv [4] = '{0, 0, 63, 6};
    logic [LIMIT_W-1:0] lens [4] = '{5'd16, 5'd31, 5'd9, 5'd13};
    for (int p = 0; p < 4; p++) begin
      write_search_len(lens[p]);
      send_idle_pct = idle_send[p];
      recv_stall_pct = idle_recv[p];
      repeat (340)
        send_request(random_request());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_search_length();
    test_backpressure_fill();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("pmp_region_decode_and_check verification clean");
    end else begin
      $display("pmp_region_decode_and_check verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pmp_rdc_pkg.sv
rtl/core/pmp_rdc_ctrl.sv
rtl/core/pmp_rdc_dpath.sv
rtl/core/pmp_region_decode_and_check.sv
rtl/core/pmp_rdc_checker.sv
sim/tb.sv
